>>> hdl/ack_retransmit_table_defines.svh
// Assertion macros for the acknowledgement retransmission table.
// Included by the top level; depends on nothing else.
`ifndef ACK_RETRANSMIT_TABLE_DEFINES_SVH
`define ACK_RETRANSMIT_TABLE_DEFINES_SVH
`ifndef SYNTH
`define ART_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ART_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ART_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ART_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/art_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the acknowledgement retransmission table.
// Used by art_cell and ack_retransmit_table; depends on nothing.
package art_pkg;

   localparam int SLOTS       = 8;
   localparam int MAX_PAYLOAD = 256;

   typedef enum logic [1:0] {
      CMD_SEND     = 2'd0,
      CMD_ACK      = 2'd1,
      CMD_TICK     = 2'd2,
      CMD_SEND_ACK = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_RESEND = 2'd1,
      KIND_ACK    = 2'd2
   } kind_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_PAR = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic [2:0] REG_OWN_NODE  = 3'd0;
   localparam logic [2:0] REG_TIMEOUT   = 3'd1;
   localparam logic [2:0] REG_RETRY_LIM = 3'd2;
   localparam logic [2:0] REG_TTL       = 3'd3;
   localparam logic [2:0] REG_SEND_EN   = 3'd4;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  peer_node;
      logic [7:0]  seq_num;
      logic [7:0]  trans_tag;
      logic [7:0]  payload_ref;
      logic [15:0] payload_len;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [1:0] status;
      logic [7:0] frame_src;
      logic [7:0] frame_dst;
      logic [7:0] frame_trans;
      logic [7:0] frame_seq;
      logic [7:0] frame_ttl;
      logic [7:0] frame_payload_ref;
      logic [9:0] frame_len;
      logic       last;
   } rsp_type;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      logic        send_go;
      logic        ack_go;
      logic        tick_go;
      logic        pop;
      logic        send_en;
      logic [7:0]  peer;
      logic [7:0]  seq;
      logic [7:0]  tag;
      logic [7:0]  ref_id;
      logic [9:0]  len;
      logic [31:0] now;
      logic [31:0] timeout;
      logic [3:0]  limit;
   } ctrl_type;

   // Handed from each cell to its higher neighbour.
   typedef struct packed {
      logic       free_seen;
      logic       match_seen;
      logic       pend_seen;
      logic       pend_more;
      logic [7:0] dest;
      logic [7:0] trans;
      logic [7:0] seq;
      logic [7:0] ref_id;
      logic [9:0] len;
   } link_type;

endpackage

>>> hdl/ack_retransmit_table.sv
`timescale 1ns / 1ps
// Top level of the acknowledgement retransmission table: cell chain,
// configuration registers and result register. Depends on art_pkg, art_cell.
//
//   channel  prefix  direction  handshake
//   request  req_    in         valid / ready
//   result   rsp_    out        valid / ready
//   config   csr_    in         write enable, no wait
//
// A tick updates all slots together, then emits one resend frame per
// result transfer from the lowest pending slot upwards.
// Requests are refused while frames are pending or the result register is full and rsp_ready is low.
// Reset clears all slots and restores the register defaults.
`include "ack_retransmit_table_defines.svh"
module ack_retransmit_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  art_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output art_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   logic [7:0]  own_node_ff;
   logic [31:0] timeout_ff;
   logic [3:0]  limit_ff;
   logic [7:0]  ttl_ff;
   logic        send_en_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   art_pkg::rsp_type rsp_data_ff, rsp_data_in;

   art_pkg::ctrl_type ctrl;
   art_pkg::link_type links [art_pkg::SLOTS+1];
   art_pkg::link_type chain_end;

   logic out_free, accept, len_ok, pop;

   assign chain_end = links[art_pkg::SLOTS];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = out_free && !chain_end.pend_seen;
   assign accept    = req_valid && req_ready;
   assign len_ok    = ({16'd0, req_data.payload_len} <= 32'(art_pkg::MAX_PAYLOAD));
   assign pop       = out_free && chain_end.pend_seen;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff <= 8'd0;
         timeout_ff  <= 32'd1000;
         limit_ff    <= 4'd3;
         ttl_ff      <= 8'd8;
         send_en_ff  <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            art_pkg::REG_OWN_NODE:  own_node_ff <= csr_wdata[7:0];
            art_pkg::REG_TIMEOUT:   timeout_ff  <= csr_wdata;
            art_pkg::REG_RETRY_LIM: limit_ff    <= csr_wdata[3:0];
            art_pkg::REG_TTL:       ttl_ff      <= csr_wdata[7:0];
            art_pkg::REG_SEND_EN:   send_en_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Command broadcast to the cells.
   always_comb begin
      ctrl.send_go = accept && (req_data.command == art_pkg::CMD_SEND) && len_ok;
      ctrl.ack_go  = accept && (req_data.command == art_pkg::CMD_ACK);
      ctrl.tick_go = accept && (req_data.command == art_pkg::CMD_TICK);
      ctrl.pop     = pop;
      ctrl.send_en = send_en_ff;
      ctrl.peer    = req_data.peer_node;
      ctrl.seq     = req_data.seq_num;
      ctrl.tag     = req_data.trans_tag;
      ctrl.ref_id  = req_data.payload_ref;
      ctrl.len     = req_data.payload_len[9:0];
      ctrl.now     = req_data.now_ms;
      ctrl.timeout = timeout_ff;
      ctrl.limit   = limit_ff;
   end

   assign links[0] = '0;

   for (genvar i = 0; i < art_pkg::SLOTS; i++) begin : g_cell
      art_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .link_in  (links[i]),
         .link_out (links[i+1])
      );
   end

   // Result register: resend frames from the chain, or the single result of
   // a send or send-ack.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in                   = '0;
         rsp_data_in.result_kind       = art_pkg::KIND_RESEND;
         rsp_data_in.status            = art_pkg::ST_OK;
         rsp_data_in.frame_src         = own_node_ff;
         rsp_data_in.frame_dst         = chain_end.dest;
         rsp_data_in.frame_trans       = chain_end.trans;
         rsp_data_in.frame_seq         = chain_end.seq;
         rsp_data_in.frame_ttl         = ttl_ff;
         rsp_data_in.frame_payload_ref = chain_end.ref_id;
         rsp_data_in.frame_len         = chain_end.len;
         rsp_data_in.last              = !chain_end.pend_more;
      end else if (accept && (req_data.command == art_pkg::CMD_SEND)) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in              = '0;
         rsp_data_in.result_kind  = art_pkg::KIND_STATUS;
         rsp_data_in.status       = !len_ok ? art_pkg::ST_BAD_PAR :
                                    chain_end.free_seen ? art_pkg::ST_OK : art_pkg::ST_FULL;
         rsp_data_in.last         = 1'b1;
      end else if (accept && (req_data.command == art_pkg::CMD_SEND_ACK)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in.last = 1'b1;
         if (send_en_ff) begin
            rsp_data_in.result_kind = art_pkg::KIND_ACK;
            rsp_data_in.status      = art_pkg::ST_OK;
            rsp_data_in.frame_src   = own_node_ff;
            rsp_data_in.frame_dst   = req_data.peer_node;
            rsp_data_in.frame_seq   = req_data.seq_num;
            rsp_data_in.frame_ttl   = ttl_ff;
         end else begin
            rsp_data_in.result_kind = art_pkg::KIND_STATUS;
            rsp_data_in.status      = art_pkg::ST_BAD_PAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A request is never taken while resend frames are still queued.
   `ART_ASSERT_IMPLY(a_no_req_while_pend, clock, reset, req_ready, !chain_end.pend_seen)
   // A send always yields a status result in the next cycle.
   `ART_ASSERT_NEXT(a_send_answers, clock, reset,
      accept && (req_data.command == art_pkg::CMD_SEND), rsp_valid && rsp_data.last)
   // An ack frame is always the only result of its request.
   `ART_ASSERT_IMPLY(a_ack_last, clock, reset,
      rsp_valid && (rsp_data.result_kind == art_pkg::KIND_ACK), rsp_data.last)

endmodule

>>> hdl/art_cell.sv
`timescale 1ns / 1ps
// One slot of the retransmission table with its priority link.
// Depends on art_pkg.
module art_cell (
   input  logic              clock,
   input  logic              reset,
   input  art_pkg::ctrl_type ctrl,
   input  art_pkg::link_type link_in,
   output art_pkg::link_type link_out
);

   logic        active_ff, active_in;
   logic        armed_ff, armed_in;
   logic        pend_ff, pend_in;
   logic [7:0]  dest_ff, dest_in;
   logic [7:0]  seq_ff, seq_in;
   logic [7:0]  trans_ff, trans_in;
   logic [7:0]  ref_ff, ref_in;
   logic [9:0]  len_ff, len_in;
   logic [3:0]  retries_ff, retries_in;
   logic [31:0] deadline_ff, deadline_in;
   logic [31:0] diff;
   logic        take, matched, first_pend;

   assign diff       = ctrl.now - deadline_ff;
   assign take       = ctrl.send_go && !link_in.free_seen && !active_ff;
   assign matched    = active_ff && (dest_ff == ctrl.peer) && (seq_ff == ctrl.seq);
   assign first_pend = pend_ff && !link_in.pend_seen;

   // Slot update for the command in hand.
   always_comb begin
      active_in   = active_ff;
      armed_in    = armed_ff;
      pend_in     = pend_ff;
      dest_in     = dest_ff;
      seq_in      = seq_ff;
      trans_in    = trans_ff;
      ref_in      = ref_ff;
      len_in      = len_ff;
      retries_in  = retries_ff;
      deadline_in = deadline_ff;
      if (take) begin
         active_in  = 1'b1;
         armed_in   = 1'b0;
         dest_in    = ctrl.peer;
         seq_in     = ctrl.seq;
         trans_in   = ctrl.tag;
         ref_in     = ctrl.ref_id;
         len_in     = ctrl.len;
         retries_in = 4'd0;
      end
      if (ctrl.ack_go && !link_in.match_seen && matched) begin
         active_in = 1'b0;
      end
      if (ctrl.tick_go && active_ff) begin
         if (!armed_ff) begin
            armed_in    = 1'b1;
            deadline_in = ctrl.now + ctrl.timeout;
         end else if (!diff[31]) begin
            if (retries_ff >= ctrl.limit) begin
               active_in = 1'b0;
            end else begin
               pend_in     = ctrl.send_en;
               retries_in  = (retries_ff == 4'hF) ? retries_ff : retries_ff + 4'd1;
               deadline_in = ctrl.now + ctrl.timeout;
            end
         end
      end
      if (ctrl.pop && first_pend) begin
         pend_in = 1'b0;
      end
   end

   // Priority link: the lowest pending slot carries its frame data upwards.
   always_comb begin
      link_out            = link_in;
      link_out.free_seen  = link_in.free_seen || !active_ff;
      link_out.match_seen = link_in.match_seen || matched;
      link_out.pend_seen  = link_in.pend_seen || pend_ff;
      link_out.pend_more  = link_in.pend_more || (link_in.pend_seen && pend_ff);
      if (first_pend) begin
         link_out.dest   = dest_ff;
         link_out.trans  = trans_ff;
         link_out.seq    = seq_ff;
         link_out.ref_id = ref_ff;
         link_out.len    = len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         armed_ff  <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         armed_ff  <= armed_in;
         pend_ff   <= pend_in;
      end
      dest_ff     <= dest_in;
      seq_ff      <= seq_in;
      trans_ff    <= trans_in;
      ref_ff      <= ref_in;
      len_ff      <= len_in;
      retries_ff  <= retries_in;
      deadline_ff <= deadline_in;
   end

endmodule
